/* sv/ihmdk_pkg.sv */
// ----------------------------------------------------------------------------
// ihmdk_pkg : shared definitions for the indexed min-heap
// Action and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ihmdk_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int ID_BITS      = 10;
    localparam int ACT_BITS     = 11;
    localparam int ACTION_BITS  = 2;
    localparam int STATUS_BITS  = 2;
    localparam logic [ACT_BITS-1:0] ACT_RESET = 11'd1024;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INIT    = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_CHANGE  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ITEM = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_CK_POS,
        S_CK_SLOT,
        S_UP_S,
        S_UP_C,
        S_DN_S,
        S_DN_L,
        S_DN_R,
        S_EX_B,
        S_EX_C,
        S_FINAL,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* sv/indexed_min_heap_decrease_key.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key : indexed binary min-heap with change-key
// Requests arrive on the s_ stream (s_tuser selects init, extract or change
// key); each request returns exactly one response on the m_ stream.
// ----------------------------------------------------------------------------
// Usage:
//   One request is taken at a time; s_tready is high only while the sequencer
//   waits for work. Each request yields one response (key, item, status).
//   Init fills n = min(active_count, CAPACITY) slots, one a cycle, then sifts
//   the start item to the root.
//   The pace is set by the single read port of the slot memory: each heap
//   level costs one read for the parent, or two for the children, plus the
//   compare and write-back step.
//   The response sits in an output register; a new request is accepted while
//   it waits, and the sequencer holds its next response until m_tready.
//   Reset empties the heap (count zero) and sets active_count to 1024; the
//   memories need no clearing. cfg_we writes active_count; the user must do
//   so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_decrease_key #(
    parameter int CAPACITY = ihmdk_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ihmdk_pkg::KEY_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [ihmdk_pkg::ACT_BITS-1:0]         cfg_data,
    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    // s_tdata: item_id, new_key, zero padding
    input  wire logic [((ihmdk_pkg::ID_BITS+KEY_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: action
    input  wire logic [ihmdk_pkg::ACTION_BITS-1:0]      s_tuser,
    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    // m_tdata: out_key, out_id, zero padding
    output      logic [((ihmdk_pkg::ID_BITS+KEY_BITS+7)/8)*8-1:0] m_tdata,
    // m_tuser: status
    output      logic [ihmdk_pkg::STATUS_BITS-1:0]      m_tuser
);
    import ihmdk_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam int LW = AW + 2;
    localparam int NW = (CW > ACT_BITS) ? CW : ACT_BITS;
    localparam int DW = ((ID_BITS + KEY_BITS + 7) / 8) * 8;
    localparam logic [KEY_BITS-1:0] KEY_INF = {KEY_BITS{1'b1}};

    // Memories
    logic [KEY_BITS-1:0] keys_mem  [CAPACITY];
    logic [AW-1:0]       items_mem [CAPACITY];
    logic [AW-1:0]       pos_mem   [CAPACITY];

    logic                slot_we;
    logic [AW-1:0]       slot_wa;
    logic [KEY_BITS-1:0] slot_wk;
    logic [AW-1:0]       slot_wi;
    logic                pos_we;
    logic [AW-1:0]       pos_wa;
    logic [AW-1:0]       pos_wd;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       pos_rd_addr;

    logic [KEY_BITS-1:0] rk_reg;
    logic [AW-1:0]       ri_reg;
    logic [AW-1:0]       rp_reg;

    // Sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [AW-1:0]       hole_reg, hole_next;
    logic [KEY_BITS-1:0] mkey_reg, mkey_next;
    logic [AW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [ACT_BITS-1:0] act_reg;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [KEY_BITS-1:0] lkey_reg, lkey_next;
    logic [AW-1:0]       lid_reg, lid_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    logic [ID_BITS-1:0]  res_id_reg, res_id_next;
    status_t             status_reg, status_next;
    logic                m_valid_reg;
    logic [KEY_BITS-1:0] m_key_reg;
    logic [ID_BITS-1:0]  m_id_reg;
    status_t             m_status_reg;

    logic                s_acc;
    logic                out_free;
    logic [ID_BITS-1:0]  in_id;
    logic [KEY_BITS-1:0] in_key;
    logic [NW-1:0]       act_w;
    logic [CW-1:0]       n_sat;
    logic [AW-1:0]       parent;
    logic [LW-1:0]       left_idx;
    logic [LW-1:0]       right_idx;
    logic [LW-1:0]       cnt_l;
    logic [LW-1:0]       id_l;
    logic [LW-1:0]       cap_l;

    assign in_id     = s_tdata[ID_BITS-1:0];
    assign in_key    = s_tdata[ID_BITS+KEY_BITS-1:ID_BITS];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign act_w     = NW'(act_reg);
    assign n_sat     = (act_w > NW'(CAPACITY)) ? CW'(CAPACITY) : CW'(act_w);
    assign parent    = AW'((hole_reg - AW'(1)) >> 1);
    assign left_idx  = {1'b0, hole_reg, 1'b1};
    assign right_idx = left_idx + LW'(1);
    assign cnt_l     = LW'(cnt_reg);
    assign id_l      = LW'(id_reg);
    assign cap_l     = LW'(CAPACITY);

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            keys_mem[slot_wa]  <= slot_wk;
            items_mem[slot_wa] <= slot_wi;
        end
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        rk_reg <= keys_mem[rd_addr];
        ri_reg <= items_mem[rd_addr];
        rp_reg <= pos_mem[pos_rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    unique case (action_t'(s_tuser))
                        ACT_INIT:    state_next = S_FILL;
                        ACT_EXTRACT: state_next = (cnt_reg == '0) ? S_DONE : S_EX_B;
                        ACT_CHANGE:  state_next = (LW'(in_id) >= cap_l) ? S_DONE : S_CK_POS;
                        ACT_NONE:    state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:
            begin
                if (fill_reg >= cnt_reg)
                begin
                    state_next = (id_l < cnt_l) ? S_UP_S : S_DONE;
                end
            end
            S_CK_POS:  state_next = (CW'(rp_reg) >= cnt_reg) ? S_DONE : S_CK_SLOT;
            S_CK_SLOT:
            begin
                if (ri_reg != AW'(id_reg))
                    state_next = S_DONE;
                else if (mkey_reg < rk_reg)
                    state_next = S_UP_S;
                else
                    state_next = S_DN_S;
            end
            S_UP_S:    state_next = (hole_reg == '0) ? S_FINAL : S_UP_C;
            S_UP_C:    state_next = (mkey_reg < rk_reg) ? S_UP_S : S_FINAL;
            S_DN_S:    state_next = (left_idx >= cnt_l) ? S_FINAL : S_DN_L;
            S_DN_L:
            begin
                if (right_idx < cnt_l)
                    state_next = S_DN_R;
                else
                    state_next = (rk_reg < mkey_reg) ? S_DN_S : S_FINAL;
            end
            S_DN_R:
            begin
                if (lkey_reg < mkey_reg || rk_reg < mkey_reg)
                    state_next = S_DN_S;
                else
                    state_next = S_FINAL;
            end
            S_EX_B:    state_next = S_EX_C;
            S_EX_C:    state_next = (cnt_reg == CW'(1)) ? S_DONE : S_DN_S;
            S_FINAL:   state_next = S_DONE;
            S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls
    always_comb
    begin
        hole_next    = hole_reg;
        mkey_next    = mkey_reg;
        mid_next     = mid_reg;
        cnt_next     = cnt_reg;
        fill_next    = fill_reg;
        id_next      = id_reg;
        lkey_next    = lkey_reg;
        lid_next     = lid_reg;
        res_key_next = res_key_reg;
        res_id_next  = res_id_reg;
        status_next  = status_reg;
        slot_we      = 1'b0;
        slot_wa      = hole_reg;
        slot_wk      = mkey_reg;
        slot_wi      = mid_reg;
        pos_we       = 1'b0;
        pos_wa       = mid_reg;
        pos_wd       = hole_reg;
        rd_addr      = '0;
        pos_rd_addr  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    id_next      = in_id;
                    mkey_next    = in_key;
                    res_key_next = '0;
                    res_id_next  = '0;
                    status_next  = ST_OK;
                    unique case (action_t'(s_tuser))
                        ACT_INIT:
                        begin
                            cnt_next  = n_sat;
                            fill_next = '0;
                        end
                        ACT_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                                status_next = ST_EMPTY;
                        end
                        ACT_CHANGE:
                        begin
                            if (LW'(in_id) >= cap_l)
                                status_next = ST_BAD_ITEM;
                            pos_rd_addr = AW'(in_id);
                        end
                        ACT_NONE: ;
                    endcase
                end
            end
            // Load slots below the count with infinite keys, items and positions in step
            S_FILL:
            begin
                if (fill_reg < cnt_reg)
                begin
                    slot_we   = 1'b1;
                    slot_wa   = AW'(fill_reg);
                    slot_wk   = KEY_INF;
                    slot_wi   = AW'(fill_reg);
                    pos_we    = 1'b1;
                    pos_wa    = AW'(fill_reg);
                    pos_wd    = AW'(fill_reg);
                    fill_next = fill_reg + CW'(1);
                end
                else if (id_l < cnt_l)
                begin
                    mkey_next = '0;
                    mid_next  = AW'(id_reg);
                    hole_next = AW'(id_reg);
                end
                else
                begin
                    status_next = ST_BAD_ITEM;
                end
            end
            // Look up the slot that the position map names
            S_CK_POS:
            begin
                if (CW'(rp_reg) >= cnt_reg)
                    status_next = ST_BAD_ITEM;
                rd_addr   = rp_reg;
                hole_next = rp_reg;
            end
            S_CK_SLOT:
            begin
                if (ri_reg != AW'(id_reg))
                    status_next = ST_BAD_ITEM;
                mid_next = AW'(id_reg);
            end
            S_UP_S:
            begin
                rd_addr = parent;
            end
            // Pull the parent down into the hole
            S_UP_C:
            begin
                if (mkey_reg < rk_reg)
                begin
                    slot_we   = 1'b1;
                    slot_wk   = rk_reg;
                    slot_wi   = ri_reg;
                    pos_we    = 1'b1;
                    pos_wa    = ri_reg;
                    hole_next = parent;
                end
            end
            S_DN_S:
            begin
                rd_addr = AW'(left_idx);
            end
            S_DN_L:
            begin
                lkey_next = rk_reg;
                lid_next  = ri_reg;
                rd_addr   = AW'(right_idx);
                if (!(right_idx < cnt_l) && rk_reg < mkey_reg)
                begin
                    slot_we   = 1'b1;
                    slot_wk   = rk_reg;
                    slot_wi   = ri_reg;
                    pos_we    = 1'b1;
                    pos_wa    = ri_reg;
                    hole_next = AW'(left_idx);
                end
            end
            // Pick the smaller child, left first on ties, and lift it
            S_DN_R:
            begin
                if (lkey_reg < mkey_reg)
                begin
                    if (rk_reg < lkey_reg)
                    begin
                        slot_wk   = rk_reg;
                        slot_wi   = ri_reg;
                        hole_next = AW'(right_idx);
                    end
                    else
                    begin
                        slot_wk   = lkey_reg;
                        slot_wi   = lid_reg;
                        hole_next = AW'(left_idx);
                    end
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                    pos_wa  = slot_wi;
                end
                else if (rk_reg < mkey_reg)
                begin
                    slot_we   = 1'b1;
                    slot_wk   = rk_reg;
                    slot_wi   = ri_reg;
                    pos_we    = 1'b1;
                    pos_wa    = ri_reg;
                    hole_next = AW'(right_idx);
                end
            end
            // Root is the answer; fetch the last slot as the moving pair
            S_EX_B:
            begin
                res_key_next = rk_reg;
                res_id_next  = ID_BITS'(ri_reg);
                rd_addr      = AW'(cnt_reg - CW'(1));
            end
            S_EX_C:
            begin
                mkey_next = rk_reg;
                mid_next  = ri_reg;
                cnt_next  = cnt_reg - CW'(1);
                hole_next = '0;
            end
            // Drop the moving pair into its hole
            S_FINAL:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            act_reg     <= ACT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
                act_reg <= cfg_data;
            if (state_reg == S_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg    <= hole_next;
        mkey_reg    <= mkey_next;
        mid_reg     <= mid_next;
        fill_reg    <= fill_next;
        id_reg      <= id_next;
        lkey_reg    <= lkey_next;
        lid_reg     <= lid_next;
        res_key_reg <= res_key_next;
        res_id_reg  <= res_id_next;
        status_reg  <= status_next;
        if (state_reg == S_DONE && out_free)
        begin
            m_key_reg    <= res_key_reg;
            m_id_reg     <= res_id_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DW'({m_id_reg, m_key_reg});
    assign m_tuser  = m_status_reg;

    // Checks
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(CAPACITY) >= cnt_reg)
        else $error("heap count above capacity");

    a_hole_in: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_S || state_reg == S_DN_S || state_reg == S_FINAL)
        |-> CW'(hole_reg) < cnt_reg)
        else $error("sift hole outside the heap");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && action_t'(s_tuser) == ACT_EXTRACT && cnt_reg == '0)
        |=> (status_reg == ST_EMPTY && state_reg == S_DONE))
        else $error("empty extract not flagged");

    a_write_in: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_we && state_reg != S_FILL) |-> CW'(slot_wa) < cnt_reg)
        else $error("slot write outside the heap");

endmodule

`default_nettype wire
